// ----- sv/renc_pkg.sv -----
// shared types, field codes and the frame check for the encoder position link
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package renc_pkg;

   localparam logic [2:0] KIND_TICK       = 3'd0;
   localparam logic [2:0] KIND_REQUEST    = 3'd1;
   localparam logic [2:0] KIND_BYTE       = 3'd2;
   localparam logic [2:0] KIND_READ       = 3'd3;
   localparam logic [2:0] KIND_LINE_ERROR = 3'd4;

   localparam logic REG_RESPONSE_TIMEOUT = 1'b0;
   localparam logic REG_COMMAND_BYTE     = 1'b1;

   localparam logic [7:0] TIMEOUT_RESET = 8'd10;
   localparam logic [7:0] COMMAND_RESET = 8'h54;
   localparam logic [1:0] CHECK_SEED    = 2'h3;
   localparam int         POS_W         = 14;
   localparam int         COUNT_W       = 16;

   typedef struct packed {
      logic [7:0] response_timeout;
      logic [7:0] command_byte;
   } cfg_type;

   typedef struct packed {
      logic               tx_valid;
      logic [7:0]         tx_data;
      logic [POS_W-1:0]   position;
      logic               position_valid;
      logic               checksum_bad;
      logic               timed_out;
      logic [COUNT_W-1:0] checksum_error_total;
      logic [COUNT_W-1:0] line_error_total;
      logic               busy_res;
   } rsp_type;

   // check bits are the seed xor the seven pairs of the low 14 bits
   function automatic logic frame_ok(input logic [15:0] word);
      logic [1:0] cs;
      cs = CHECK_SEED;
      for (int i = 0; i < 7; i++) begin
         cs = cs ^ word[2*i +: 2];
      end
      return cs == word[15:14];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ----- sv/renc_if.sv -----
// request and response channel interfaces for the encoder position link
// field widths are written out here and match renc_pkg; no package is imported
`timescale 1ns / 1ps
`default_nettype none

interface renc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] rx_data;

   modport source (output valid, kind, rx_data, input ready);
   modport sink (input valid, kind, rx_data, output ready);
endinterface

interface renc_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_valid;
   logic [7:0]  tx_data;
   logic [13:0] position;
   logic        position_valid;
   logic        checksum_bad;
   logic        timed_out;
   logic [15:0] checksum_error_total;
   logic [15:0] line_error_total;
   logic        busy_res;

   modport source (output valid, tx_valid, tx_data, position, position_valid,
                   checksum_bad, timed_out, checksum_error_total,
                   line_error_total, busy_res, input ready);
   modport sink (input valid, tx_valid, tx_data, position, position_valid,
                 checksum_bad, timed_out, checksum_error_total,
                 line_error_total, busy_res, output ready);
endinterface

`default_nettype wire

// ----- sv/renc_core.sv -----
// link state and per-item update: timer, frame assembly, check, counters
// depends on renc_pkg
`timescale 1ns / 1ps
`default_nettype none

module renc_core
   import renc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire logic [2:0] kind,
   input  wire logic [7:0] rx_data,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic               awaiting_ff, awaiting_in;
   logic [7:0]         elapsed_ff, elapsed_in;
   logic               byte_count_ff, byte_count_in;
   logic [7:0]         first_byte_ff, first_byte_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic               fresh_ff, fresh_in;
   logic [COUNT_W-1:0] cs_errors_ff, cs_errors_in;
   logic [COUNT_W-1:0] line_errors_ff, line_errors_in;
   logic [15:0]        word;

   assign word = {rx_data, first_byte_ff};

   always_comb begin
      awaiting_in    = awaiting_ff;
      elapsed_in     = elapsed_ff;
      byte_count_in  = byte_count_ff;
      first_byte_in  = first_byte_ff;
      position_in    = position_ff;
      fresh_in       = fresh_ff;
      cs_errors_in   = cs_errors_ff;
      line_errors_in = line_errors_ff;
      result         = '0;
      case (kind)
         KIND_TICK: begin
            if (awaiting_ff) begin
               if (elapsed_ff != 8'hFF) elapsed_in = elapsed_ff + 1'b1;
               if (elapsed_in >= cfg.response_timeout) begin
                  awaiting_in    = 1'b0;
                  byte_count_in  = 1'b0;
                  result.timed_out = 1'b1;
               end
            end
         end
         KIND_REQUEST: begin
            result.tx_valid = 1'b1;
            result.tx_data  = cfg.command_byte;
            awaiting_in     = 1'b1;
            elapsed_in      = '0;
            byte_count_in   = 1'b0;
         end
         KIND_BYTE: begin
            // bytes outside a pending request are dropped
            if (awaiting_ff) begin
               if (!byte_count_ff) begin
                  first_byte_in = rx_data;
                  byte_count_in = 1'b1;
               end else begin
                  byte_count_in = 1'b0;
                  if (frame_ok(word)) begin
                     position_in = word[POS_W-1:0];
                     awaiting_in = 1'b0;
                     fresh_in    = 1'b1;
                  end else begin
                     cs_errors_in        = sat_inc(cs_errors_ff);
                     result.checksum_bad = 1'b1;
                  end
               end
            end
         end
         KIND_READ: begin
            if (fresh_ff) begin
               result.position_valid = 1'b1;
               fresh_in              = 1'b0;
            end
         end
         KIND_LINE_ERROR: begin
            line_errors_in = sat_inc(line_errors_ff);
         end
         default: begin
         end
      endcase
      result.position             = position_in;
      result.checksum_error_total = cs_errors_in;
      result.line_error_total     = line_errors_in;
      result.busy_res             = awaiting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff    <= 1'b0;
         elapsed_ff     <= '0;
         byte_count_ff  <= 1'b0;
         first_byte_ff  <= '0;
         position_ff    <= '0;
         fresh_ff       <= 1'b0;
         cs_errors_ff   <= '0;
         line_errors_ff <= '0;
      end else if (fire) begin
         awaiting_ff    <= awaiting_in;
         elapsed_ff     <= elapsed_in;
         byte_count_ff  <= byte_count_in;
         first_byte_ff  <= first_byte_in;
         position_ff    <= position_in;
         fresh_ff       <= fresh_in;
         cs_errors_ff   <= cs_errors_in;
         line_errors_ff <= line_errors_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rs485_encoder_position_link.sv -----
// encoder position link, master side: input register, update logic, result register
// an accepted item is held in the input register, then updated and held in the result register
// throughput: one item per cycle, limited only by the result side taking items
// reset (synchronous, active high) clears the link state, both stages and the
// configuration back to a timeout of 10 ticks and command byte 0x54
`timescale 1ns / 1ps
`default_nettype none

module rs485_encoder_position_link
   import renc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   renc_req_if.sink   req_chan,
   renc_rsp_if.source rsp_chan,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_index,
   input  wire logic [7:0] csr_write_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [2:0] in_kind_ff;
   logic [7:0] in_rx_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   rsp_type    result;
   logic       out_load;
   logic       fire;

   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && out_load;
   assign req_chan.ready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.response_timeout <= TIMEOUT_RESET;
         cfg_ff.command_byte     <= COMMAND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RESPONSE_TIMEOUT: cfg_ff.response_timeout <= csr_write_data;
            REG_COMMAND_BYTE:     cfg_ff.command_byte     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_kind_ff <= req_chan.kind;
         in_rx_ff   <= req_chan.rx_data;
      end
   end

   renc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .kind    (in_kind_ff),
      .rx_data (in_rx_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.tx_valid             = out_ff.tx_valid;
   assign rsp_chan.tx_data              = out_ff.tx_data;
   assign rsp_chan.position             = out_ff.position;
   assign rsp_chan.position_valid       = out_ff.position_valid;
   assign rsp_chan.checksum_bad         = out_ff.checksum_bad;
   assign rsp_chan.timed_out            = out_ff.timed_out;
   assign rsp_chan.checksum_error_total = out_ff.checksum_error_total;
   assign rsp_chan.line_error_total     = out_ff.line_error_total;
   assign rsp_chan.busy_res             = out_ff.busy_res;

endmodule

`default_nettype wire
